### hw/rtl/fcf_pkg.sv
// shared constants and types for the fir convolution filter
package fcf_pkg;

   localparam int DEFAULT_MAX_TAPS     = 128;
   localparam int DEFAULT_SAMPLE_WIDTH = 16;
   localparam int TAP_INDEX_WIDTH      = 7;
   localparam int TAP_COUNT_WIDTH      = 8;
   localparam int ACC_WIDTH            = 64;

   localparam logic [TAP_COUNT_WIDTH-1:0] TAP_COUNT_RESET = 8'd101;

   localparam logic KIND_COEF   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef logic [ACC_WIDTH-1:0] acc_type;

endpackage

### hw/rtl/fcf_if.sv
// request and response channel interfaces of the fir convolution filter
interface fcf_req_if #(
   parameter int SAMPLE_WIDTH = fcf_pkg::DEFAULT_SAMPLE_WIDTH
);
   import fcf_pkg::*;

   logic                              valid;
   logic                              ready;
   logic                              kind;
   logic [TAP_INDEX_WIDTH-1:0]        tap_index;
   logic signed [SAMPLE_WIDTH-1:0]    value;

   modport source (output valid, output kind, output tap_index, output value, input ready);
   modport sink   (input valid, input kind, input tap_index, input value, output ready);
endinterface

interface fcf_rsp_if #(
   parameter int SAMPLE_WIDTH = fcf_pkg::DEFAULT_SAMPLE_WIDTH
);
   logic                              valid;
   logic                              ready;
   logic signed [SAMPLE_WIDTH-1:0]    filtered_sample;
   logic                              saturated;

   modport source (output valid, output filtered_sample, output saturated, input ready);
   modport sink   (input valid, input filtered_sample, input saturated, output ready);
endinterface

### hw/rtl/fcf_ram.sv
// generic single-port-write, single-port-read ram with registered read
module fcf_ram #(
   parameter int WIDTH = fcf_pkg::DEFAULT_SAMPLE_WIDTH,
   parameter int DEPTH = fcf_pkg::DEFAULT_MAX_TAPS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/fir_convolution_filter_unit.sv
// Direct-form FIR filter with a loadable coefficient store and a sample history ram.
// A coefficient item (kind 0) is written to the coefficient ram and gives no result.
// A sample item (kind 1) is written into the history ram, then one shared multiplier
// walks the configured taps, one tap per cycle, reading one coefficient and one
// history entry per cycle. Products are summed in a 64-bit accumulator, rounded half
// up to Q1.15 and saturated, with saturated set when clipping occurs. History entries
// not yet filled since reset count as zero through a fill count, so no clearing pass
// is needed. The tap count register value is clamped to 1 .. MAX_TAPS when a sample
// is taken, and a coefficient index beyond the store is ignored. The next item may be
// accepted while the previous result waits on the response channel.
module fir_convolution_filter_unit #(
   parameter int MAX_TAPS     = fcf_pkg::DEFAULT_MAX_TAPS,
   parameter int SAMPLE_WIDTH = fcf_pkg::DEFAULT_SAMPLE_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [fcf_pkg::TAP_COUNT_WIDTH-1:0]   csr_wr_data,
   fcf_req_if.sink                               req_chan,
   fcf_rsp_if.source                             rsp_chan
);
   import fcf_pkg::*;

   localparam int AW   = $clog2(MAX_TAPS);
   localparam int CW   = $clog2(MAX_TAPS + 1);
   localparam int SW   = SAMPLE_WIDTH;
   localparam int PW   = 2 * SAMPLE_WIDTH;
   localparam int FRAC = SAMPLE_WIDTH - 1;

   localparam acc_type ROUND_HALF = acc_type'(1) << (FRAC - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MAC   = 3'd1;
   localparam logic [2:0] S_WAIT  = 3'd2;
   localparam logic [2:0] S_ROUND = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   // control registers
   logic [2:0]                 state_ff, state_in;
   logic [TAP_COUNT_WIDTH-1:0] tap_count_ff, tap_count_in;
   logic [AW-1:0]              ptr_ff, ptr_in;
   logic [CW-1:0]              fill_ff, fill_in;
   logic [CW-1:0]              taps_ff, taps_in;
   logic [CW-1:0]              k_ff, k_in;
   logic [AW-1:0]              slot_ff, slot_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic                       rd_last_ff, rd_last_in;
   logic                       prod_vld_ff, prod_vld_in;
   logic                       prod_last_ff, prod_last_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic                       rd_zero_ff, rd_zero_in;
   logic signed [PW-1:0]       prod_ff, prod_in;
   acc_type                    acc_ff, acc_in;
   logic [SW-1:0]              rsp_sample_ff, rsp_sample_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   logic                       req_accept;
   logic                       sample_accept;
   logic                       coef_write;
   logic [AW-1:0]              ptr_next;
   logic [AW-1:0]              slot_dec;
   logic                       last_issue;
   logic [31:0]                cnt_wide;
   logic [CW-1:0]              taps_clamp;
   logic [SW-1:0]              coef_rd;
   logic [SW-1:0]              hist_rd;
   logic signed [PW-1:0]       mul;
   logic signed [ACC_WIDTH-1:0] shifted;
   logic                       sat_hi;
   logic                       sat_lo;

   assign req_chan.ready          = (state_ff == S_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.filtered_sample = rsp_sample_ff;
   assign rsp_chan.saturated      = rsp_sat_ff;

   assign req_accept    = req_chan.valid && req_chan.ready;
   assign sample_accept = req_accept && (req_chan.kind == KIND_SAMPLE);
   assign coef_write    = req_accept && (req_chan.kind == KIND_COEF)
                          && (32'(req_chan.tap_index) < 32'(MAX_TAPS));

   assign ptr_next   = (ptr_ff == AW'(MAX_TAPS - 1)) ? '0 : ptr_ff + AW'(1);
   assign slot_dec   = (slot_ff == '0) ? AW'(MAX_TAPS - 1) : slot_ff - AW'(1);
   assign last_issue = (state_ff == S_MAC) && (k_ff == taps_ff - CW'(1));

   assign mul     = $signed(coef_rd) * $signed(hist_rd);
   assign shifted = $signed(acc_ff) >>> FRAC;
   assign sat_hi  = !shifted[ACC_WIDTH-1] && (|shifted[ACC_WIDTH-2:SW-1]);
   assign sat_lo  = shifted[ACC_WIDTH-1] && !(&shifted[ACC_WIDTH-2:SW-1]);

   always_comb begin
      cnt_wide = 32'(tap_count_ff);
      if (cnt_wide == 32'd0) begin
         taps_clamp = CW'(1);
      end else if (cnt_wide > 32'(MAX_TAPS)) begin
         taps_clamp = CW'(MAX_TAPS);
      end else begin
         taps_clamp = CW'(cnt_wide);
      end
   end

   fcf_ram #(.WIDTH(SW), .DEPTH(MAX_TAPS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_write),
      .wr_addr (AW'(req_chan.tap_index)),
      .wr_data (req_chan.value),
      .rd_addr (k_ff[AW-1:0]),
      .rd_data (coef_rd)
   );

   fcf_ram #(.WIDTH(SW), .DEPTH(MAX_TAPS)) u_hist_ram (
      .clock   (clock),
      .wr_en   (sample_accept),
      .wr_addr (ptr_next),
      .wr_data (req_chan.value),
      .rd_addr (slot_ff),
      .rd_data (hist_rd)
   );

   always_comb begin
      state_in      = state_ff;
      tap_count_in  = csr_wr_en ? csr_wr_data : tap_count_ff;
      ptr_in        = ptr_ff;
      fill_in       = fill_ff;
      taps_in       = taps_ff;
      k_in          = k_ff;
      slot_in       = slot_ff;
      rd_vld_in     = (state_ff == S_MAC);
      rd_last_in    = last_issue;
      rd_zero_in    = (k_ff >= fill_ff);
      prod_vld_in   = rd_vld_ff;
      prod_last_in  = rd_last_ff;
      prod_in       = rd_zero_ff ? '0 : mul;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_sat_in    = rsp_sat_ff;

      case (state_ff)
         S_IDLE: begin
            if (sample_accept) begin
               state_in = S_MAC;
               ptr_in   = ptr_next;
               slot_in  = ptr_next;
               fill_in  = (fill_ff == CW'(MAX_TAPS)) ? fill_ff : fill_ff + CW'(1);
               taps_in  = taps_clamp;
               k_in     = '0;
               acc_in   = '0;
            end
         end
         S_MAC: begin
            k_in    = k_ff + CW'(1);
            slot_in = slot_dec;
            if (last_issue) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (prod_vld_ff) begin
               acc_in = acc_ff + ACC_WIDTH'(prod_ff);
               if (prod_last_ff) begin
                  state_in = S_ROUND;
               end
            end
         end
         S_ROUND: begin
            acc_in   = acc_ff + ROUND_HALF;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sat_in   = sat_hi || sat_lo;
               if (sat_hi) begin
                  rsp_sample_in = {1'b0, {(SW - 1){1'b1}}};
               end else if (sat_lo) begin
                  rsp_sample_in = {1'b1, {(SW - 1){1'b0}}};
               end else begin
                  rsp_sample_in = shifted[SW-1:0];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // products still in flight while issuing
      if (state_ff == S_MAC && prod_vld_ff) begin
         acc_in = acc_ff + ACC_WIDTH'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tap_count_ff <= TAP_COUNT_RESET;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         taps_ff      <= CW'(1);
         k_ff         <= '0;
         slot_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         prod_vld_ff  <= 1'b0;
         prod_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_count_ff <= tap_count_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         taps_ff      <= taps_in;
         k_ff         <= k_in;
         slot_ff      <= slot_in;
         rd_vld_ff    <= rd_vld_in;
         rd_last_ff   <= rd_last_in;
         prod_vld_ff  <= prod_vld_in;
         prod_last_ff <= prod_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_zero_ff    <= rd_zero_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_sat_ff    <= rsp_sat_in;
   end
endmodule

### hw/rtl/fcf_checker.sv
// port-level assertions for the fir convolution filter, bound to the top level
module fcf_checker #(
   parameter int SAMPLE_WIDTH = fcf_pkg::DEFAULT_SAMPLE_WIDTH
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    req_kind,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [SAMPLE_WIDTH-1:0] rsp_filtered_sample,
   input logic                    rsp_saturated
);
   import fcf_pkg::*;

   localparam int SW = SAMPLE_WIDTH;

   // result item holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_filtered_sample) && $stable(rsp_saturated))
      else $error("rsp payload changed while stalled");

   // clipped output sits at a range limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_filtered_sample == {1'b0, {(SW - 1){1'b1}}})
         || (rsp_filtered_sample == {1'b1, {(SW - 1){1'b0}}}))
      else $error("saturated item not at a range limit");

   // a sample item keeps the block busy
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_SAMPLE) |=> !req_ready)
      else $error("ready high right after a sample item");

   // the block is ready again in the cycle after a coefficient item
   a_coef_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_COEF) |=> req_ready)
      else $error("ready low right after a coefficient item");
endmodule

bind fir_convolution_filter_unit fcf_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_fcf_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .req_kind            (req_chan.kind),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_filtered_sample (rsp_chan.filtered_sample),
   .rsp_saturated       (rsp_chan.saturated)
);
